>>> design/srp_pkg.sv
package srp_pkg;

  // protocol constants
  localparam logic [7:0] SOCKS_VERSION = 8'h05;
  localparam logic [7:0] RSV_VALUE     = 8'h00;
  localparam logic [7:0] ATYP_IPV4     = 8'h01;
  localparam logic [7:0] ATYP_DOMAIN   = 8'h03;
  localparam logic [7:0] ATYP_IPV6     = 8'h04;
  localparam logic [7:0] LEN_IPV4      = 8'd4;
  localparam logic [7:0] LEN_IPV6      = 8'd16;

  // status codes
  localparam logic [1:0] ST_BUSY  = 2'd0;
  localparam logic [1:0] ST_DONE  = 2'd1;
  localparam logic [1:0] ST_ERROR = 2'd2;

  // phase codes as shown on the result
  localparam logic [2:0] PHASE_VERSION  = 3'd0;
  localparam logic [2:0] PHASE_COMMAND  = 3'd1;
  localparam logic [2:0] PHASE_RESERVED = 3'd2;
  localparam logic [2:0] PHASE_ATYPE    = 3'd3;
  localparam logic [2:0] PHASE_DOMLEN   = 3'd4;
  localparam logic [2:0] PHASE_ADDRESS  = 3'd5;
  localparam logic [2:0] PHASE_PORT     = 3'd6;
  localparam logic [2:0] PHASE_END      = 3'd7;

  localparam int ITEM_TDATA_W  = 8;
  localparam int RESULT_TDATA_W = 64;

  // parser state, one-hot
  typedef enum logic [7:0] {
    PH_VERSION  = 8'b0000_0001,
    PH_COMMAND  = 8'b0000_0010,
    PH_RESERVED = 8'b0000_0100,
    PH_ATYPE    = 8'b0000_1000,
    PH_DOMLEN   = 8'b0001_0000,
    PH_ADDRESS  = 8'b0010_0000,
    PH_PORT     = 8'b0100_0000,
    PH_END      = 8'b1000_0000
  } phase_t;

  // classified request byte as queued between front and back
  typedef struct packed {
    logic       restart;
    logic [7:0] data;
    logic       is_version;
    logic       is_zero;
    logic       is_ipv4;
    logic       is_domain;
    logic       is_ipv6;
  } srp_item_t;

  // queue status seen by the parser
  typedef struct packed {
    logic valid;
  } srp_link_t;

  function automatic logic [2:0] phase_code(input phase_t ph);
    logic [2:0] code;
    begin
      case (ph)
        PH_VERSION:  code = PHASE_VERSION;
        PH_COMMAND:  code = PHASE_COMMAND;
        PH_RESERVED: code = PHASE_RESERVED;
        PH_ATYPE:    code = PHASE_ATYPE;
        PH_DOMLEN:   code = PHASE_DOMLEN;
        PH_ADDRESS:  code = PHASE_ADDRESS;
        PH_PORT:     code = PHASE_PORT;
        default:     code = PHASE_END;
      endcase
      return code;
    end
  endfunction

endpackage

>>> design/srp_front.sv
module srp_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             in_data,
  input  logic                   in_restart,
  output srp_pkg::srp_item_t     item,
  input  logic                   item_pop,
  output logic                   item_valid
);
  import srp_pkg::*;

  srp_item_t   mem [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        push;
  logic        pop;
  srp_item_t   classified;

  // classify the byte on the way in
  always_comb begin
    classified.restart    = in_restart;
    classified.data       = in_data;
    classified.is_version = (in_data == SOCKS_VERSION);
    classified.is_zero    = (in_data == RSV_VALUE);
    classified.is_ipv4    = (in_data == ATYP_IPV4);
    classified.is_domain  = (in_data == ATYP_DOMAIN);
    classified.is_ipv6    = (in_data == ATYP_IPV6);
  end

  assign in_ready   = (count != 2'd2);
  assign item_valid = (count != 2'd0);
  assign item       = mem[rd_ptr];
  assign push       = in_valid && in_ready;
  assign pop        = item_valid && item_pop;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= classified;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> design/srp_parser.sv
module srp_parser (
  input  logic                                clk,
  input  logic                                rst,
  input  srp_pkg::srp_item_t                  item,
  input  srp_pkg::srp_link_t                  link_in,
  output logic                                pop,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [srp_pkg::RESULT_TDATA_W-1:0]  out_data
);
  import srp_pkg::*;

  phase_t      phase, phase_next;
  logic        failed, failed_next;
  logic [7:0]  command_reg, command_reg_next;
  logic [7:0]  atyp_reg, atyp_reg_next;
  logic [7:0]  expected_length, expected_length_next;
  logic [7:0]  address_count, address_count_next;
  logic [15:0] port_accum, port_accum_next;
  logic [1:0]  port_count, port_count_next;
  logic        a_valid;
  logic [7:0]  a_byte;
  logic [7:0]  a_index;
  logic [7:0]  count_inc;
  logic [1:0]  status_next;
  logic        take;

  assign take = link_in.valid && (!out_valid || out_ready);
  assign pop  = take;
  assign count_inc = address_count + 8'd1;

  always_comb begin
    phase_next           = phase;
    failed_next          = failed;
    command_reg_next     = command_reg;
    atyp_reg_next        = atyp_reg;
    expected_length_next = expected_length;
    address_count_next   = address_count;
    port_accum_next      = port_accum;
    port_count_next      = port_count;
    a_valid              = 1'b0;
    a_byte               = 8'd0;
    a_index              = 8'd0;
    if (item.restart) begin
      phase_next           = PH_VERSION;
      failed_next          = 1'b0;
      command_reg_next     = 8'd0;
      atyp_reg_next        = 8'd0;
      expected_length_next = 8'd0;
      address_count_next   = 8'd0;
      port_accum_next      = 16'd0;
      port_count_next      = 2'd0;
    end else begin
      case (phase)
        PH_VERSION: begin
          if (item.is_version) begin
            phase_next = PH_COMMAND;
          end else begin
            phase_next  = PH_END;
            failed_next = 1'b1;
          end
        end
        PH_COMMAND: begin
          command_reg_next = item.data;
          phase_next       = PH_RESERVED;
        end
        PH_RESERVED: begin
          if (item.is_zero) begin
            phase_next = PH_ATYPE;
          end else begin
            phase_next  = PH_END;
            failed_next = 1'b1;
          end
        end
        PH_ATYPE: begin
          atyp_reg_next      = item.data;
          address_count_next = 8'd0;
          if (item.is_ipv4) begin
            expected_length_next = LEN_IPV4;
            phase_next           = PH_ADDRESS;
          end else if (item.is_ipv6) begin
            expected_length_next = LEN_IPV6;
            phase_next           = PH_ADDRESS;
          end else if (item.is_domain) begin
            phase_next = PH_DOMLEN;
          end else begin
            phase_next  = PH_END;
            failed_next = 1'b1;
          end
        end
        PH_DOMLEN: begin
          expected_length_next = item.data;
          address_count_next   = 8'd0;
          if (item.is_zero) begin
            phase_next  = PH_END;
            failed_next = 1'b1;
          end else begin
            phase_next = PH_ADDRESS;
          end
        end
        PH_ADDRESS: begin
          a_valid            = 1'b1;
          a_byte             = item.data;
          a_index            = address_count;
          address_count_next = count_inc;
          if (count_inc == expected_length) begin
            port_accum_next = 16'd0;
            port_count_next = 2'd0;
            phase_next      = PH_PORT;
          end
        end
        PH_PORT: begin
          port_accum_next = {port_accum[7:0], item.data};
          port_count_next = port_count + 2'd1;
          if (port_count == 2'd1) begin
            phase_next = PH_END;
          end
        end
        default: begin
        end
      endcase
    end
    if (phase_next != PH_END) begin
      status_next = ST_BUSY;
    end else if (failed_next) begin
      status_next = ST_ERROR;
    end else begin
      status_next = ST_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_VERSION;
      failed          <= 1'b0;
      command_reg     <= 8'd0;
      atyp_reg        <= 8'd0;
      expected_length <= 8'd0;
      address_count   <= 8'd0;
      port_accum      <= 16'd0;
      port_count      <= 2'd0;
      out_valid       <= 1'b0;
    end else begin
      if (take) begin
        phase           <= phase_next;
        failed          <= failed_next;
        command_reg     <= command_reg_next;
        atyp_reg        <= atyp_reg_next;
        expected_length <= expected_length_next;
        address_count   <= address_count_next;
        port_accum      <= port_accum_next;
        port_count      <= port_count_next;
        out_valid       <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register, loaded only when a request is taken
  always_ff @(posedge clk) begin
    if (take) begin
      out_data <= {2'd0, port_accum_next, expected_length_next, a_index, a_byte, a_valid,
                   atyp_reg_next, command_reg_next, phase_code(phase_next), status_next};
    end
  end

endmodule

>>> design/socks5_request_parser.sv
// socks5 connect request parser: takes one request byte per s_tvalid/s_tready
// handshake (s_tuser high restarts the parser and the byte is ignored) and
// returns exactly one result per request showing the parser state after that
// byte: status, phase, command, address type, the address byte with its
// index when one was consumed, the expected address length and the
// big-endian destination port. a new request is accepted every cycle while
// neither side stalls; the byte is written into the front queue when accepted
// and then taken into the result register once that register is free, and the
// phase update in the back-end parser is done as each byte is taken into the
// result register, which sustains the rate of one request per cycle.
// the two-entry queue and the result register let either side stall alone.
module socks5_request_parser (
  input  logic                                clk,
  input  logic                                rst,
  // request stream
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [srp_pkg::ITEM_TDATA_W-1:0]    s_tdata,   // [7:0] data_byte
  input  logic                                s_tuser,   // [0] restart
  // result stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [1:0] status, [4:2] phase, [12:5] command, [20:13] address_type,
  // [21] addr_byte_valid, [29:22] addr_byte, [37:30] addr_index,
  // [45:38] address_length, [61:46] dest_port, [63:62] zero
  output logic [srp_pkg::RESULT_TDATA_W-1:0]  m_tdata
);
  import srp_pkg::*;

  srp_item_t item;
  srp_link_t link;
  logic      item_valid;
  logic      item_pop;

  // front: classify bytes and queue them
  srp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_data    (s_tdata),
    .in_restart (s_tuser),
    .item       (item),
    .item_pop   (item_pop),
    .item_valid (item_valid)
  );

  assign link.valid = item_valid;

  // back: phase machine and result register
  srp_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .link_in   (link),
    .pop       (item_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule

>>> design/srp_checker.sv
module srp_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                s_tvalid,
  input logic                                s_tready,
  input logic [srp_pkg::ITEM_TDATA_W-1:0]    s_tdata,
  input logic                                s_tuser,
  input logic                                m_tvalid,
  input logic                                m_tready,
  input logic [srp_pkg::RESULT_TDATA_W-1:0]  m_tdata
);
  import srp_pkg::*;

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // end phase exactly when done or error
  a_status_phase: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[4:2] == PHASE_END) == (m_tdata[1:0] != ST_BUSY)))
    else $error("status and phase disagree");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[1:0] == ST_BUSY || m_tdata[1:0] == ST_DONE ||
                  m_tdata[1:0] == ST_ERROR))
    else $error("bad status code");

  // address bytes only leave the address phase or move into port phase
  a_addr_phase: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[21] |-> (m_tdata[4:2] == PHASE_ADDRESS || m_tdata[4:2] == PHASE_PORT))
    else $error("address byte outside address phase");

  // a restart request shows a cleared state
  a_restart: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[4:2] == PHASE_VERSION |-> m_tdata[61:5] == 57'd0)
    else $error("version phase with stale fields");

endmodule

bind socks5_request_parser srp_checker u_srp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

>>> dv/socks5_request_parser_tb.sv
module socks5_request_parser_tb;
  import srp_pkg::*;

  // result word as packed by the block, msb first
  typedef struct packed {
    logic [1:0]  pad;
    logic [15:0] dest_port;
    logic [7:0]  address_length;
    logic [7:0]  addr_index;
    logic [7:0]  addr_byte;
    logic        addr_byte_valid;
    logic [7:0]  address_type;
    logic [7:0]  command;
    logic [2:0]  phase;
    logic [1:0]  status;
  } parse_result_t;

  // one request byte, with an optional hand-written expectation
  typedef struct {
    logic [7:0]    data;
    logic          restart;
    logic          typed;
    parse_result_t want;
  } stim_t;

  localparam int STALL_LIMIT = 2000;
  localparam int LONG_HOLD   = 80;
  localparam int TAIL_CYCLES = 10;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;

  socks5_request_parser u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // parser state as the testbench sees it
  logic [2:0]  prs_phase = PHASE_VERSION;
  logic [7:0]  prs_cmd = '0;
  logic [7:0]  prs_atyp = '0;
  logic [7:0]  prs_len = '0;
  logic [7:0]  prs_count = '0;
  logic [15:0] prs_port = '0;
  logic [1:0]  prs_port_cnt = '0;
  logic        prs_failed = 1'b0;

  stim_t         stim_q[$];
  stim_t         directed_tbl[$];
  stim_t         offered;
  parse_result_t expected_results_q[$];
  parse_result_t predicted;

  logic req_taken = 1'b0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   hold_asked = 0;
  int   hold_seen = 0;
  int   hold_left = 0;
  int   stall_cycles = 0;
  int   gen_count = 0;
  int   mismatch_cnt = 0;
  int   reqs_accepted = 0;
  int   restarts_taken = 0;
  int   results_checked = 0;
  int   addr_bytes_seen = 0;
  int   backpressure_cycles = 0;
  int   full_requests = 0;
  int   broken_requests = 0;

  // next parser state and the result shown after one request byte
  function automatic parse_result_t parse_request_byte(input logic [7:0] b, input logic rs);
    parse_result_t r;
    r = '0;
    if (rs) begin
      prs_phase = PHASE_VERSION;
      prs_cmd = '0;
      prs_atyp = '0;
      prs_len = '0;
      prs_count = '0;
      prs_port = '0;
      prs_port_cnt = '0;
      prs_failed = 1'b0;
    end else begin
      case (prs_phase)
        PHASE_VERSION: begin
          if (b != SOCKS_VERSION) begin
            prs_phase = PHASE_END;
            prs_failed = 1'b1;
          end else prs_phase = PHASE_COMMAND;
        end
        PHASE_COMMAND: begin
          prs_cmd = b;
          prs_phase = PHASE_RESERVED;
        end
        PHASE_RESERVED: begin
          if (b != RSV_VALUE) begin
            prs_phase = PHASE_END;
            prs_failed = 1'b1;
          end else prs_phase = PHASE_ATYPE;
        end
        PHASE_ATYPE: begin
          prs_atyp = b;
          prs_count = '0;
          if (b == ATYP_IPV4) begin
            prs_len = LEN_IPV4;
            prs_phase = PHASE_ADDRESS;
          end else if (b == ATYP_IPV6) begin
            prs_len = LEN_IPV6;
            prs_phase = PHASE_ADDRESS;
          end else if (b == ATYP_DOMAIN) begin
            prs_phase = PHASE_DOMLEN;
          end else begin
            prs_phase = PHASE_END;
            prs_failed = 1'b1;
          end
        end
        PHASE_DOMLEN: begin
          prs_len = b;
          prs_count = '0;
          if (b == 8'd0) begin
            prs_phase = PHASE_END;
            prs_failed = 1'b1;
          end else prs_phase = PHASE_ADDRESS;
        end
        PHASE_ADDRESS: begin
          r.addr_byte_valid = 1'b1;
          r.addr_byte = b;
          r.addr_index = prs_count;
          prs_count = prs_count + 8'd1;
          if (prs_count == prs_len) begin
            prs_port = '0;
            prs_port_cnt = '0;
            prs_phase = PHASE_PORT;
          end
        end
        PHASE_PORT: begin
          prs_port = {prs_port[7:0], b};
          prs_port_cnt = prs_port_cnt + 2'd1;
          if (prs_port_cnt == 2'd2) prs_phase = PHASE_END;
        end
        default: ;
      endcase
    end
    if (prs_phase != PHASE_END) r.status = ST_BUSY;
    else r.status = prs_failed ? ST_ERROR : ST_DONE;
    r.phase = prs_phase;
    r.command = prs_cmd;
    r.address_type = prs_atyp;
    r.address_length = prs_len;
    r.dest_port = prs_port;
    return r;
  endfunction

  function automatic string fmt_result(input parse_result_t r);
    return $sformatf("st=%0d ph=%0d cmd=%02h atyp=%02h av=%0b ab=%02h ai=%0d len=%0d port=%04h pad=%0d",
                     r.status, r.phase, r.command, r.address_type, r.addr_byte_valid,
                     r.addr_byte, r.addr_index, r.address_length, r.dest_port, r.pad);
  endfunction

  function automatic stim_t row(input logic [7:0] d, input logic rs);
    stim_t s;
    s.data = d;
    s.restart = rs;
    s.typed = 1'b0;
    s.want = '0;
    return s;
  endfunction

  // hand-written expectation; these rows never carry an address byte
  function automatic stim_t row_exp(input logic [7:0] d, input logic rs, input logic [1:0] st,
                                    input logic [2:0] ph, input logic [7:0] cmd,
                                    input logic [7:0] atyp, input logic [7:0] len,
                                    input logic [15:0] port);
    stim_t s;
    s = row(d, rs);
    s.typed = 1'b1;
    s.want.status = st;
    s.want.phase = ph;
    s.want.command = cmd;
    s.want.address_type = atyp;
    s.want.address_length = len;
    s.want.dest_port = port;
    return s;
  endfunction

  task automatic check_result(input parse_result_t got);
    parse_result_t want;
    logic bad;
    results_checked++;
    if (got.addr_byte_valid === 1'b1) addr_bytes_seen++;
    if (expected_results_q.size() == 0) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10) $display("result with nothing pending: %s", fmt_result(got));
    end else begin
      want = expected_results_q.pop_front();
      bad = (got.status !== want.status) || (got.phase !== want.phase) ||
            (got.command !== want.command) || (got.address_type !== want.address_type) ||
            (got.addr_byte_valid !== want.addr_byte_valid) ||
            (got.addr_byte !== want.addr_byte) || (got.addr_index !== want.addr_index) ||
            (got.address_length !== want.address_length) ||
            (got.dest_port !== want.dest_port) || (got.pad !== want.pad);
      if (bad) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
          $display("mismatch %0d at result %0d", mismatch_cnt, results_checked);
          $display("  expected %s", fmt_result(want));
          $display("  actual   %s", fmt_result(got));
        end
      end
    end
  endtask

  task automatic push_byte(input logic [7:0] d, input logic rs, input logic counts);
    stim_q.push_back(row(d, rs));
    if (counts) gen_count++;
  endtask

  // a complete connect request with random content, or a random prefix of one
  task automatic push_wellformed(input logic truncate);
    logic [7:0] seq[$];
    logic [7:0] at;
    int len;
    int cut;
    seq.push_back(SOCKS_VERSION);
    seq.push_back(8'($urandom));
    seq.push_back(RSV_VALUE);
    case ($urandom_range(2))
      0: at = ATYP_IPV4;
      1: at = ATYP_DOMAIN;
      default: at = ATYP_IPV6;
    endcase
    seq.push_back(at);
    if (at == ATYP_IPV4) len = LEN_IPV4;
    else if (at == ATYP_IPV6) len = LEN_IPV6;
    else begin
      // mostly short names, now and then a long one up to the maximum
      len = ($urandom_range(99) < 3) ? $urandom_range(255, 128) : $urandom_range(12, 1);
      seq.push_back(8'(len));
    end
    repeat (len) seq.push_back(8'($urandom));
    repeat (2) seq.push_back(8'($urandom));
    cut = truncate ? $urandom_range(seq.size() - 1, 1) : seq.size();
    for (int i = 0; i < cut; i++) push_byte(seq[i], 1'b0, 1'b1);
  endtask

  task automatic gen_requests(input int target);
    logic [7:0] b;
    while (gen_count < target) begin
      push_byte(8'($urandom), 1'b1, 1'b1);
      if ($urandom_range(99) < 72) begin
        full_requests++;
        push_wellformed(1'b0);
        repeat ($urandom_range(2)) push_byte(8'($urandom), 1'b0, 1'b0);
      end else begin
        broken_requests++;
        case ($urandom_range(5))
          0: begin
            b = 8'($urandom);
            if (b == SOCKS_VERSION) b = ~b;
            push_byte(b, 1'b0, 1'b1);
            push_byte(8'($urandom), 1'b0, 1'b0);
          end
          1: begin
            push_byte(SOCKS_VERSION, 1'b0, 1'b1);
            push_byte(8'($urandom), 1'b0, 1'b1);
            push_byte(8'($urandom_range(255, 1)), 1'b0, 1'b1);
          end
          2: begin
            b = 8'($urandom);
            if (b == ATYP_IPV4 || b == ATYP_DOMAIN || b == ATYP_IPV6) b = b | 8'h80;
            push_byte(SOCKS_VERSION, 1'b0, 1'b1);
            push_byte(8'($urandom), 1'b0, 1'b1);
            push_byte(RSV_VALUE, 1'b0, 1'b1);
            push_byte(b, 1'b0, 1'b1);
          end
          3: begin
            push_byte(SOCKS_VERSION, 1'b0, 1'b1);
            push_byte(8'($urandom), 1'b0, 1'b1);
            push_byte(RSV_VALUE, 1'b0, 1'b1);
            push_byte(ATYP_DOMAIN, 1'b0, 1'b1);
            push_byte(8'd0, 1'b0, 1'b1);
          end
          4: push_wellformed(1'b1);
          default: begin
            // raw noise with the odd restart mixed in
            push_byte(8'($urandom), 1'b0, 1'b1);
            repeat ($urandom_range(5)) push_byte(8'($urandom), $urandom_range(7) == 0, 1'b0);
          end
        endcase
      end
    end
  endtask

  function automatic logic outstanding();
    return (stim_q.size() != 0) || s_tvalid || (expected_results_q.size() != 0);
  endfunction

  task automatic wait_drained();
    while (outstanding()) @(posedge clk);
  endtask

  // request driver, changes only at the falling edge
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || req_taken) begin
      if (stim_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        offered = stim_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= offered.data;
        s_tuser <= offered.restart;
      end else s_tvalid <= 1'b0;
    end
  end

  // result receiver with random stalls and a single long hold-off
  always @(negedge clk) begin
    if (hold_seen != hold_asked) begin
      hold_seen = hold_asked;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // sample both handshakes at the rising edge
  always @(posedge clk) begin
    req_taken = 1'b0;
    if (!rst) begin
      if (m_tvalid && m_tready) check_result(m_tdata);
      if (s_tvalid && s_tready) begin
        predicted = parse_request_byte(s_tdata, s_tuser);
        if (offered.typed) expected_results_q.push_back(offered.want);
        else expected_results_q.push_back(predicted);
        req_taken = 1'b1;
        reqs_accepted++;
        if (s_tuser) restarts_taken++;
      end
      if (s_tvalid && !s_tready) backpressure_cycles++;
      if ((m_tvalid && m_tready) || req_taken) stall_cycles = 0;
      else if (outstanding()) stall_cycles++;
    end
  end

  // watchdog on cycles without progress
  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("no handshake for %0d cycles", STALL_LIMIT);
    $display("socks5_request_parser_tb: FAIL");
    $finish;
  end

  initial begin
    // error cases and a one-byte domain request, each walked through once
    directed_tbl = '{
      row_exp(8'hFF, 1'b1, ST_BUSY,  PHASE_VERSION, 8'h00, 8'h00, 8'd0, 16'h0000),
      row_exp(8'h04, 1'b0, ST_ERROR, PHASE_END,     8'h00, 8'h00, 8'd0, 16'h0000),
      row_exp(8'h05, 1'b0, ST_ERROR, PHASE_END,     8'h00, 8'h00, 8'd0, 16'h0000),
      row_exp(8'h00, 1'b1, ST_BUSY,  PHASE_VERSION, 8'h00, 8'h00, 8'd0, 16'h0000),
      row(SOCKS_VERSION, 1'b0),
      row(8'hFF, 1'b0),
      row_exp(8'h80, 1'b0, ST_ERROR, PHASE_END,     8'hFF, 8'h00, 8'd0, 16'h0000),
      row_exp(8'h00, 1'b1, ST_BUSY,  PHASE_VERSION, 8'h00, 8'h00, 8'd0, 16'h0000),
      row(SOCKS_VERSION, 1'b0),
      row(8'h00, 1'b0),
      row(RSV_VALUE, 1'b0),
      row_exp(8'hFF, 1'b0, ST_ERROR, PHASE_END,     8'h00, 8'hFF, 8'd0, 16'h0000),
      row(8'h00, 1'b1),
      row(SOCKS_VERSION, 1'b0),
      row(8'h7F, 1'b0),
      row(RSV_VALUE, 1'b0),
      row(ATYP_DOMAIN, 1'b0),
      row_exp(8'h00, 1'b0, ST_ERROR, PHASE_END,     8'h7F, ATYP_DOMAIN, 8'd0, 16'h0000),
      row(8'h55, 1'b1),
      row(SOCKS_VERSION, 1'b0),
      row(8'h01, 1'b0),
      row(RSV_VALUE, 1'b0),
      row(ATYP_DOMAIN, 1'b0),
      row(8'h01, 1'b0),
      row(8'hAA, 1'b0),
      row(8'hFF, 1'b0),
      row_exp(8'hFF, 1'b0, ST_DONE,  PHASE_END,     8'h01, ATYP_DOMAIN, 8'd1, 16'hFFFF),
      row_exp(8'h12, 1'b0, ST_DONE,  PHASE_END,     8'h01, ATYP_DOMAIN, 8'd1, 16'hFFFF)
    };

    repeat (2) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    @(posedge clk);

    foreach (directed_tbl[i]) stim_q.push_back(directed_tbl[i]);
    wait_drained();

    // random requests under four handshake regimes
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      gen_count = 0;
      gen_requests(200);
      // back the result side up while requests keep coming
      if (ph == 0) hold_asked++;
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);

    $display("sent %0d request bytes (%0d restarts): %0d complete and %0d malformed requests",
             reqs_accepted, restarts_taken, full_requests, broken_requests);
    $display("checked %0d results, %0d address bytes, input back-pressured %0d cycles",
             results_checked, addr_bytes_seen, backpressure_cycles);
    if (expected_results_q.size() != 0)
      $display("%0d results never arrived", expected_results_q.size());
    if (mismatch_cnt != 0) $display("%0d mismatches in total", mismatch_cnt);
    if (mismatch_cnt == 0 && expected_results_q.size() == 0) begin
      $display("socks5_request_parser_tb: PASS");
    end else begin
      $display("socks5_request_parser_tb: FAIL");
    end
    $finish;
  end

endmodule
